FILE: sv/b64e_pkg.sv
package b64e_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CharW   = 7;
  localparam int unsigned SextetW = 6;
  localparam int unsigned GroupW  = 3 * ByteW;

  // ASCII '=' used for padding positions
  localparam logic [CharW-1:0] PadChar = 7'h3D;

  // One 3-byte group, left aligned and zero padded, as handed from front to back.
  typedef struct packed {
    logic [GroupW-1:0] word;
    logic [1:0]        nbytes;  // 1..3 valid bytes
    logic              last;    // group ends the message
  } group_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [CharW-1:0] sextet_to_char(input logic [SextetW-1:0] idx);
    logic [CharW-1:0] c;
    c = {1'b0, idx};
    if (idx < 6'd26) begin
      c = 7'h41 + {1'b0, idx};
    end else if (idx < 6'd52) begin
      c = 7'h61 + {1'b0, idx - 6'd26};
    end else if (idx < 6'd62) begin
      c = 7'h30 + {1'b0, idx - 6'd52};
    end else if (idx == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

FILE: sv/b64e_if.sv
interface b64e_byte_if import b64e_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_char_if import b64e_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] code_char;
  logic             end_of_message;

  modport source (output valid, output code_char, output end_of_message, input ready);
  modport sink   (input valid, input code_char, input end_of_message, output ready);
endinterface

FILE: sv/b64e_front.sv
module b64e_front import b64e_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             final_byte_i,
  input  logic             q_full_i,
  output logic             push_o,
  output group_t           group_o
);

  logic [2*ByteW-1:0] held_q, held_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [1:0]         have;
  logic [1:0]         count;
  logic               accept;
  logic               complete;
  logic [GroupW-1:0]  joined;

  assign ready_o  = !q_full_i;
  assign accept   = valid_i && ready_o;
  assign have     = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
  assign count    = have + 2'd1;
  assign complete = (count == 2'd3) || final_byte_i;
  assign joined   = {held_q, data_byte_i};
  assign push_o   = accept && complete;

  always_comb begin
    group_o.nbytes = count;
    group_o.last   = final_byte_i;
    case (count)
      2'd1:    group_o.word = {data_byte_i, {(2*ByteW){1'b0}}};
      2'd2:    group_o.word = {held_q[ByteW-1:0], data_byte_i, {ByteW{1'b0}}};
      default: group_o.word = joined;
    endcase
  end

  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (complete) begin
        held_d = '0;
        cnt_d  = '0;
      end else begin
        held_d = {held_q[ByteW-1:0], data_byte_i};
        cnt_d  = count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

FILE: sv/b64e_fifo.sv
module b64e_fifo import b64e_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  group_t wdata_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output group_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  group_t            slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: sv/b64e_back.sv
module b64e_back import b64e_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  group_t           group_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [CharW-1:0] code_char_o,
  output logic             end_of_message_o
);

  group_t             cur_q;
  logic               cur_valid_q;
  logic [1:0]         pos_q;
  logic               out_valid_q;
  logic [CharW-1:0]   char_q;
  logic               eom_q;
  logic               advance;
  logic               load;
  logic [SextetW-1:0] sextet;
  logic [CharW-1:0]   next_char;

  assign advance = cur_valid_q && (!out_valid_q || ready_i);
  assign load    = !q_empty_i && (!cur_valid_q || (advance && pos_q == 2'd3));
  assign pop_o   = load;

  always_comb begin
    case (pos_q)
      2'd0:    sextet = cur_q.word[23:18];
      2'd1:    sextet = cur_q.word[17:12];
      2'd2:    sextet = cur_q.word[11:6];
      default: sextet = cur_q.word[5:0];
    endcase
  end

  // positions past the number of bytes are padding
  assign next_char = (pos_q > cur_q.nbytes) ? PadChar : sextet_to_char(sextet);

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= group_i;
    end
    if (advance) begin
      char_q <= next_char;
      eom_q  <= cur_q.last && (pos_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= 1'b1;
        pos_q       <= '0;
      end else if (advance) begin
        pos_q <= pos_q + 2'd1;
        if (pos_q == 2'd3) begin
          cur_valid_q <= 1'b0;
        end
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign valid_o          = out_valid_q;
  assign code_char_o      = char_q;
  assign end_of_message_o = eom_q;

endmodule

FILE: sv/base64_stream_encoder_core.sv
// Streaming base64 encoder, standard alphabet with '=' padding.
// byte_i (sink): one raw message byte per beat; final_byte marks the last
//   byte of a message and flushes a partial group.
// char_o (source): one ASCII character per beat; end_of_message is set on
//   the last character of a message (a data char or the closing '=').
// Every completed group (three bytes, or fewer at final_byte) yields
//   exactly four characters; bytes that do not close a group yield none.
// Path: the beat that closes a group writes it into the group queue; the
//   back end loads it and registers each character for char_o.
// Throughput: the back end emits one character per cycle while char_o is
//   ready, four per group, so the character serializer is the limit.
//   byte_i.ready drops only when the group queue (QueueDepth entries) is
//   full.
// Stall: a stalled char_o beat holds in the output register while the back
//   end waits; the front keeps taking bytes until the queue fills.
// Reset (rst_ni low, async): drops pending bytes, empties the queue and
//   clears the output valid. No clearing pass is needed.
module base64_stream_encoder_core import b64e_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64e_byte_if.sink   byte_i,
  b64e_char_if.source char_o
);

  group_t front_group;
  group_t back_group;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;

  // Front: gathers bytes into groups of three, closes groups on final_byte
  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (byte_i.valid),
    .ready_o      (byte_i.ready),
    .data_byte_i  (byte_i.data_byte),
    .final_byte_i (byte_i.final_byte),
    .q_full_i     (q_full),
    .push_o       (push),
    .group_o      (front_group)
  );

  // Group queue decoupling front and back
  b64e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_group),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .rdata_o (back_group)
  );

  // Back: serializes each group into four characters
  b64e_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .group_i          (back_group),
    .pop_o            (pop),
    .valid_o          (char_o.valid),
    .ready_i          (char_o.ready),
    .code_char_o      (char_o.code_char),
    .end_of_message_o (char_o.end_of_message)
  );

endmodule

FILE: sv/b64e_checker.sv
module b64e_checker import b64e_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CharW-1:0] code_char_i,
  input logic             end_of_message_i
);

  logic legal_char;
  assign legal_char = (code_char_i >= 7'h41 && code_char_i <= 7'h5A)
                   || (code_char_i >= 7'h61 && code_char_i <= 7'h7A)
                   || (code_char_i >= 7'h30 && code_char_i <= 7'h39)
                   || (code_char_i == 7'h2B) || (code_char_i == 7'h2F)
                   || (code_char_i == PadChar);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(code_char_i)
                                    && $stable(end_of_message_i))
    else $error("output beat changed while stalled");

  a_legal_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> legal_char)
    else $error("character outside base64 alphabet");

  // a non-final pad is always followed by the closing pad
  a_pad_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && code_char_i == PadChar && !end_of_message_i
      |=> !out_valid_i || (code_char_i == PadChar && end_of_message_i))
    else $error("first pad not followed by closing pad");

  // a pad is never followed by a data character within a message
  a_no_eom_on_pad_then_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && code_char_i == PadChar
      |=> !out_valid_i || code_char_i == PadChar || $past(end_of_message_i))
    else $error("data character after pad within a message");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (char_o.valid),
  .out_ready_i      (char_o.ready),
  .code_char_i      (char_o.code_char),
  .end_of_message_i (char_o.end_of_message)
);
